>>> src/xcfd_pkg.sv
package xcfd_pkg;

  localparam logic [7:0] HDR_BYTE = 8'hFD;
  localparam logic [7:0] IDX_BYTE = 8'h01;
  localparam logic [7:0] END_BYTE = 8'h0A;

  localparam logic [15:0] MIN_FRAME_LEN = 16'd3;
  localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_CSUM = 2'd1;
  localparam logic [1:0] ST_TERM = 2'd2;
  localparam logic [1:0] ST_LEN  = 2'd3;

  typedef struct packed {
    logic        is_status;
    logic [7:0]  payload_byte;
    logic [7:0]  frame_command;
    logic [1:0]  frame_status;
    logic [15:0] frame_length;
  } res_t;

endpackage

>>> src/xcfd_if.sv
interface xcfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface xcfd_res_if;
  logic        valid;
  logic        ready;
  logic        is_status;
  logic [7:0]  payload_byte;
  logic [7:0]  frame_command;
  logic [1:0]  frame_status;
  logic [15:0] frame_length;

  modport source (output valid, output is_status, output payload_byte, output frame_command,
                  output frame_status, output frame_length, input ready);
  modport sink (input valid, input is_status, input payload_byte, input frame_command,
                input frame_status, input frame_length, output ready);
endinterface

interface xcfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_frame_length;

  modport source (output valid, output max_frame_length, input ready);
  modport sink (input valid, input max_frame_length, output ready);
endinterface

>>> src/xor_checked_frame_deframer_top.sv
// frame deframer: takes received bytes on rx_i, one item per byte, hunts for the
// header 0xFD 0x01, reads a little-endian length, the command byte and the payload,
// and checks an xor checksum and the 0x0A terminator.
// res_o carries one item per payload byte (is_status low) and one closing status
// item per frame whose length field is received (is_status high, frame_status
// 0 ok, 1 checksum, 2 terminator, 3 length error).
// cfg_i writes max_frame_length (reset 1024); it is always ready and should be
// written only while no frame is in flight.
// throughput: one byte per cycle while rx_i.ready is high; the parser updates its
// state on every accepted byte, and each result item passes through a register of the output buffer before res_o.
// a two-entry output buffer lets rx_i keep taking bytes while a result waits;
// rx_i.ready drops only when both entries are full, i.e. after the receiver
// has stalled for two results.
// reset clears the parser to hunting, empties the output buffer and restores
// max_frame_length to 1024; rx_i.ready stays high during reset and bytes offered then are dropped.
module xor_checked_frame_deframer_top
  import xcfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  xcfd_rx_if.sink    rx_i,
  xcfd_res_if.source res_o,
  xcfd_cfg_if.sink   cfg_i
);

  logic accept;
  logic buf_ready;
  logic res_valid;
  res_t res;
  res_t out_data;

  assign rx_i.ready  = buf_ready;
  assign accept      = rx_i.valid && buf_ready;
  assign cfg_i.ready = 1'b1;

  xcfd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_i.valid),
    .cfg_max_len_i (cfg_i.max_frame_length),
    .accept_i      (accept),
    .rx_byte_i     (rx_i.rx_byte),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  xcfd_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_ready_o  (buf_ready),
    .in_data_i   (res),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_data_o  (out_data)
  );

  assign res_o.is_status     = out_data.is_status;
  assign res_o.payload_byte  = out_data.payload_byte;
  assign res_o.frame_command = out_data.frame_command;
  assign res_o.frame_status  = out_data.frame_status;
  assign res_o.frame_length  = out_data.frame_length;

endmodule

>>> src/xcfd_parser.sv
module xcfd_parser
  import xcfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_max_len_i,
  input  logic        accept_i,
  input  logic [7:0]  rx_byte_i,
  output logic        res_valid_o,
  output res_t        res_o
);

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_INDEX = 3'd1;
  localparam logic [2:0] PH_LENLO = 3'd2;
  localparam logic [2:0] PH_LENHI = 3'd3;
  localparam logic [2:0] PH_CMD   = 3'd4;
  localparam logic [2:0] PH_DATA  = 3'd5;
  localparam logic [2:0] PH_CHECK = 3'd6;
  localparam logic [2:0] PH_TERM  = 3'd7;

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  xor_q, xor_d;
  logic [15:0] len_q, len_d;
  logic [15:0] remain_q, remain_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] max_len_q;
  logic [15:0] full_len;
  logic [15:0] remain_dec;
  logic        emit;
  logic        emit_status;
  logic [7:0]  emit_data;
  logic [1:0]  emit_code;

  assign full_len   = {rx_byte_i, len_q[7:0]};
  assign remain_dec = (remain_q != 16'd0) ? remain_q - 16'd1 : remain_q;

  always_comb begin
    phase_d     = phase_q;
    xor_d       = xor_q;
    len_d       = len_q;
    remain_d    = remain_q;
    cmd_d       = cmd_q;
    emit        = 1'b0;
    emit_status = 1'b0;
    emit_data   = 8'd0;
    emit_code   = ST_OK;
    unique case (phase_q)
      PH_HUNT: begin
        if (rx_byte_i == HDR_BYTE) begin
          phase_d  = PH_INDEX;
          xor_d    = HDR_BYTE;
          len_d    = 16'd0;
          remain_d = 16'd0;
          cmd_d    = 8'd0;
        end
      end
      PH_INDEX: begin
        if (rx_byte_i == IDX_BYTE) begin
          xor_d   = xor_q ^ rx_byte_i;
          phase_d = PH_LENLO;
        end else if (rx_byte_i == HDR_BYTE) begin
          // header byte repeated: restart the match here
          phase_d  = PH_INDEX;
          xor_d    = HDR_BYTE;
          len_d    = 16'd0;
          remain_d = 16'd0;
          cmd_d    = 8'd0;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_LENLO: begin
        len_d   = {8'd0, rx_byte_i};
        xor_d   = xor_q ^ rx_byte_i;
        phase_d = PH_LENHI;
      end
      PH_LENHI: begin
        len_d = full_len;
        xor_d = xor_q ^ rx_byte_i;
        if (full_len < MIN_FRAME_LEN || full_len > max_len_q) begin
          phase_d     = PH_HUNT;
          emit        = 1'b1;
          emit_status = 1'b1;
          emit_code   = ST_LEN;
        end else begin
          phase_d = PH_CMD;
        end
      end
      PH_CMD: begin
        cmd_d    = rx_byte_i;
        xor_d    = xor_q ^ rx_byte_i;
        remain_d = len_q - MIN_FRAME_LEN;
        phase_d  = (len_q == MIN_FRAME_LEN) ? PH_CHECK : PH_DATA;
      end
      PH_DATA: begin
        xor_d     = xor_q ^ rx_byte_i;
        remain_d  = remain_dec;
        if (remain_dec == 16'd0) phase_d = PH_CHECK;
        emit      = 1'b1;
        emit_data = rx_byte_i;
      end
      PH_CHECK: begin
        if (rx_byte_i != xor_q) begin
          phase_d     = PH_HUNT;
          emit        = 1'b1;
          emit_status = 1'b1;
          emit_code   = ST_CSUM;
        end else begin
          phase_d = PH_TERM;
        end
      end
      PH_TERM: begin
        phase_d     = PH_HUNT;
        emit        = 1'b1;
        emit_status = 1'b1;
        emit_code   = (rx_byte_i == END_BYTE) ? ST_OK : ST_TERM;
      end
      default: phase_d = PH_HUNT;
    endcase
  end

  // result fields follow the state as updated by this byte
  assign res_valid_o = accept_i && emit;
  assign res_o = '{is_status:     emit_status,
                   payload_byte:  emit_data,
                   frame_command: cmd_d,
                   frame_status:  emit_code,
                   frame_length:  len_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      xor_q     <= 8'd0;
      len_q     <= 16'd0;
      remain_q  <= 16'd0;
      cmd_q     <= 8'd0;
      max_len_q <= MAX_LEN_RESET;
    end else begin
      if (accept_i) begin
        phase_q  <= phase_d;
        xor_q    <= xor_d;
        len_q    <= len_d;
        remain_q <= remain_d;
        cmd_q    <= cmd_d;
      end
      if (cfg_we_i) max_len_q <= cfg_max_len_i;
    end
  end

`ifndef SYNTH
  a_data_nonzero_remain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> remain_q != 16'd0)
    else $error("data phase with no bytes remaining");

  a_term_returns_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && phase_q == PH_TERM |=> phase_q == PH_HUNT)
    else $error("terminator byte did not end the frame");

  a_len_err_no_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.frame_status == ST_LEN |-> res_o.frame_command == 8'd0
      && res_o.is_status)
    else $error("length error status carries a command");
`endif

endmodule

>>> src/xcfd_skid.sv
module xcfd_skid
  import xcfd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  res_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  logic main_v_q, main_v_d;
  logic skid_v_q, skid_v_d;
  res_t main_q, main_d;
  res_t skid_q, skid_d;
  logic push;
  logic pop;

  assign in_ready_o  = !skid_v_q;
  assign out_valid_o = main_v_q;
  assign out_data_o  = main_q;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = main_v_q && out_ready_i;

  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    main_d   = main_q;
    skid_d   = skid_q;
    if (!main_v_q || pop) begin
      if (skid_v_q) begin
        main_d   = skid_q;
        main_v_d = 1'b1;
        skid_v_d = 1'b0;
      end else begin
        main_d   = in_data_i;
        main_v_d = push;
      end
    end else if (push) begin
      // main register stalled: park the item
      skid_d   = in_data_i;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

`ifndef SYNTH
  a_skid_implies_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid holds an item while main register is empty");

  a_skid_kept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !out_ready_i |=> skid_v_q && $stable(skid_q))
    else $error("parked item lost during stall");

  a_push_on_stall_parks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && main_v_q && !out_ready_i |=> skid_v_q && skid_q == $past(in_data_i))
    else $error("item pushed during stall not parked");
`endif

endmodule
